// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL; all are clocked on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define WDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication form: when cond holds, prop must hold in the same cycle.
`define WDM_ASSERT_IF(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== sv/wdm_pkg.sv =====
package wdm_pkg;

  // Default sizes
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned TanhPointsDef = 256;

  // Gain and mix scaling
  localparam int unsigned GainW = 20;  // 65536 + 9*65535 fits in 20 bits
  localparam logic [16:0] MixOne = 17'h1_0000;

  // Soft clip curve
  localparam int unsigned TanhRange = 10;
  localparam int unsigned ExpTerms  = 16;
  localparam logic [63:0] Q30One    = 64'h4000_0000;

  // Register map
  typedef enum logic [1:0] {
    RegPreGain   = 2'd0,
    RegClipThr   = 2'd1,
    RegWetMix    = 2'd2,
    RegShapeMode = 2'd3
  } cfg_reg_e;

  // Shaper selection
  typedef enum logic [1:0] {
    ShapeHard   = 2'd0,
    ShapeSoft   = 2'd1,
    ShapeRect   = 2'd2,
    ShapeBypass = 2'd3
  } shape_mode_e;

  // Register reset values
  localparam logic [15:0] PreGainRst = 16'd0;
  localparam logic [14:0] ClipThrRst = 15'h7fff;
  localparam logic [16:0] WetMixRst  = 17'h1_0000;

  // Restoring division, only used to build the tanh table at elaboration
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] quo;
    int i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f) in Q30 for 0 <= f <= 1, truncated Taylor series
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0]        term;
    logic signed [63:0] sum;
    int                 i;
    term = Q30One;
    sum  = $signed(Q30One);
    for (i = 1; i <= ExpTerms; i++) begin
      term = udiv64((term * f) >> 30, 64'(i));
      if (i[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // Table point k: tanh(10*k/(pts-1)) scaled by 2^(bits-1), clamped to max code
  function automatic logic [63:0] tanh_point(input logic [63:0] k, input logic [63:0] pts,
                                             input int unsigned bits);
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] num2;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] e1;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] res;
    logic [63:0] i;
    d    = pts - 64'd1;
    s    = 64'd1 << (bits - 1);
    num2 = 64'(2 * TanhRange) * k;
    n    = udiv64(num2, d);
    r    = num2 - n * d;
    e    = exp_neg_frac(udiv64(r << 30, d));
    e1   = exp_neg_frac(Q30One);
    for (i = 64'd0; i < n; i++) begin
      e = (e * e1) >> 30;
    end
    if (e > Q30One) e = Q30One;
    num = Q30One - e;
    den = Q30One + e;
    res = udiv64(num * 64'd2 * s + den, 64'd2 * den);
    if (res > s - 64'd1) res = s - 64'd1;
    return res;
  endfunction

endpackage

// ===== sv/waveshaper_distortion_mix_core.sv =====
// Waveshaping distortion with dry/wet mix. Each signed sample is scaled by a
// pre-gain of 1 + 9*pre_gain/65536, shaped by hard clip, interpolated tanh
// soft clip or half-wave rectifier, or passed unshaped in bypass mode, mixed
// with the dry sample by wet_mix and saturated to the sample range
// (out_saturated_o flags a clamp). The block is a nine-stage pipeline: one
// sample is taken every cycle unless the pipeline is full and the output is
// stalled. The stage cuts separate the gain, index, interpolation and mix
// multipliers. Stalls back up stage by stage, so empty stages still take new
// beats while a result waits. The tanh table has 2^clog2(TANH_POINTS)+1
// entries and is built at elaboration; there is no clearing pass after reset.
// Registers are written over the APB-style port at byte addresses 0, 4, 8 and
// 12 and should be changed only while idle.
module waveshaper_distortion_mix_core #(
  parameter int unsigned SAMPLE_BITS = wdm_pkg::SampleBitsDef,
  parameter int unsigned TANH_POINTS = wdm_pkg::TanhPointsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Input samples
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_in_i,
  // Output samples
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] sample_out_o,
  output logic                   out_saturated_o
);
  import wdm_pkg::*;

  `include "assert_macros.svh"

  // Widths
  localparam int unsigned SW        = SAMPLE_BITS;
  localparam int unsigned NumStages = 9;
  localparam int unsigned PW        = SW + GainW + 1;   // gain product
  localparam int unsigned AW        = SW + 5;           // amplified sample
  localparam int unsigned UW        = SW + 4;           // its magnitude
  localparam int unsigned DW        = $clog2(TANH_POINTS);
  localparam int unsigned TabN      = (2 ** DW) + 1;
  localparam int unsigned PosW      = UW + DW;
  localparam int unsigned ShL       = (SW <= 16) ? (16 - SW) : 0;
  localparam int unsigned ShR       = (SW > 16) ? (SW - 16) : 0;
  localparam int unsigned PosXW     = PosW + ShL;
  localparam int unsigned VW        = $clog2(5 * (TANH_POINTS - 1)) + 16;
  localparam int unsigned CW        = (AW > 16) ? AW : 16;
  localparam int unsigned IPW       = SW + 17;          // interpolation product
  localparam int unsigned MW        = AW + 18;          // mix products
  localparam int unsigned SumW      = MW + 1;
  localparam int unsigned YW        = SumW - 16;

  // Constants
  localparam logic [VW-1:0]          RecipM  = VW'((64'd1 << VW) / 5);
  localparam logic [UW-1:0]          LimVal  = UW'(64'(TanhRange) << (SW - 1));
  localparam logic [DW-1:0]          DMax    = DW'(TANH_POINTS - 1);
  localparam logic signed [PW-1:0]   RndGain = PW'(32768);
  localparam logic signed [IPW-1:0]  RndIp   = IPW'(32768);
  localparam logic signed [SumW-1:0] RndSum  = SumW'(32768);
  localparam logic signed [YW-1:0]   YMax    = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [YW-1:0]   YMin    = -YMax - YW'(1);
  localparam logic [SW-1:0]          OutMax  = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0]          OutMin  = {1'b1, {(SW - 1){1'b0}}};

  // Tanh curve, filled past the last point with the last point
  typedef logic [SW-2:0] tanh_tab_t [TabN];

  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    int unsigned k;
    int unsigned kc;
    for (k = 0; k < TabN; k++) begin
      kc     = (k > TANH_POINTS - 1) ? TANH_POINTS - 1 : k;
      tab[k] = (SW - 1)'(tanh_point(64'(kc), 64'(TANH_POINTS), SW));
    end
    return tab;
  endfunction

  localparam tanh_tab_t TanhTab = build_tanh_tab();

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [15:0] pre_gain_q;
  logic [14:0] clip_threshold_q;
  logic [16:0] wet_mix_q;
  shape_mode_e shape_mode_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_gain_q       <= PreGainRst;
      clip_threshold_q <= ClipThrRst;
      wet_mix_q        <= WetMixRst;
      shape_mode_q     <= ShapeHard;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        RegPreGain:   pre_gain_q       <= pwdata[15:0];
        RegClipThr:   clip_threshold_q <= pwdata[14:0];
        RegWetMix:    wet_mix_q        <= pwdata[16:0];
        RegShapeMode: shape_mode_q     <= shape_mode_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      RegPreGain:   prdata = 32'(pre_gain_q);
      RegClipThr:   prdata = 32'(clip_threshold_q);
      RegWetMix:    prdata = 32'(wet_mix_q);
      RegShapeMode: prdata = 32'(shape_mode_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when the next one moves
  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   en;

  always_comb begin
    en[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage registers
  logic signed [SW-1:0]   s0_x_q, s1_x_q, s2_x_q, s3_x_q, s4_x_q, s5_x_q, s6_x_q;
  logic signed [PW-1:0]   s0_prod_q;
  logic signed [AW-1:0]   s1_a_q;
  logic [PosW-1:0]        s1_pos_q;
  logic                   s1_big_q, s2_big_q;
  logic                   s2_neg_q, s3_neg_q, s4_neg_q, s5_neg_q;
  logic signed [AW-1:0]   s2_wbase_q, s3_wbase_q, s4_wbase_q, s5_wbase_q;
  logic [VW-1:0]          s2_v_q;
  logic [2*VW-1:0]        s2_prodz_q;
  logic [DW-1:0]          s3_idx_q;
  logic [15:0]            s3_q_q, s4_q_q;
  logic [SW-2:0]          s4_t0_q, s5_t0_q;
  logic signed [SW-1:0]   s4_diff_q;
  logic signed [IPW-1:0]  s5_prodi_q;
  logic signed [AW-1:0]   s6_w_q;
  logic signed [MW-1:0]   s7_dry_q, s7_wet_q;
  logic [SW-1:0]          s8_out_q;
  logic                   s8_sat_q;

  // Next values
  logic [GainW-1:0]       gain;
  logic signed [GainW:0]  gain_s;
  logic signed [SW-1:0]   x_in;
  logic signed [PW-1:0]   s0_prod_d;
  logic signed [AW-1:0]   s1_a_d;
  logic [UW-1:0]          s1_u;
  logic [PosW-1:0]        s1_pos_d;
  logic                   s1_big_d;
  logic signed [CW-1:0]   thr_c, a_c;
  logic signed [AW-1:0]   s2_wbase_d;
  logic [PosXW-1:0]       pos_x;
  logic [VW-1:0]          s2_v_d;
  logic [2*VW-1:0]        s2_prodz_d;
  logic [VW-1:0]          qe, rem5, z;
  logic [DW-1:0]          s3_idx_d;
  logic [15:0]            s3_q_d;
  logic [SW-2:0]          t0, t1;
  logic signed [SW-1:0]   s4_diff_d;
  logic signed [IPW-1:0]  s5_prodi_d;
  logic signed [SW:0]     soft_mag, soft_w;
  logic signed [AW-1:0]   s6_w_d;
  logic [16:0]            m_cl;
  logic signed [17:0]     mix_w, mix_d;
  logic signed [MW-1:0]   s7_dry_d, s7_wet_d;
  logic signed [SumW-1:0] mix_sum;
  logic signed [YW-1:0]   y;
  logic [SW-1:0]          s8_out_d;
  logic                   s8_sat_d;

  always_comb begin
    // Stage 0: pre-gain multiply with rounding offset
    gain      = (GainW'(pre_gain_q) << 3) + GainW'(pre_gain_q) + (GainW'(1) << 16);
    gain_s    = $signed({1'b0, gain});
    x_in      = $signed(sample_in_i);
    s0_prod_d = x_in * gain_s + RndGain;

    // Stage 1: amplified sample, magnitude, table position
    s1_a_d   = $signed(s0_prod_q[PW-1:16]);
    s1_u     = s1_a_d[AW-1] ? UW'(-s1_a_d) : UW'(s1_a_d);
    s1_pos_d = PosW'(s1_u) * PosW'(DMax);
    s1_big_d = (s1_u >= LimVal);

    // Stage 2: non-table shapers, scaled position times 1/5
    thr_c = CW'($signed({1'b0, clip_threshold_q}));
    a_c   = CW'(s1_a_q);
    case (shape_mode_q)
      ShapeHard: begin
        if (a_c > thr_c)       s2_wbase_d = AW'(thr_c);
        else if (a_c < -thr_c) s2_wbase_d = AW'(-thr_c);
        else                   s2_wbase_d = s1_a_q;
      end
      ShapeRect: s2_wbase_d = s1_a_q[AW-1] ? '0 : s1_a_q;
      default:   s2_wbase_d = s1_a_q;
    endcase
    pos_x      = PosXW'(s1_pos_q) << ShL;
    s2_v_d     = VW'(pos_x >> ShR);
    s2_prodz_d = (2 * VW)'(s2_v_d) * (2 * VW)'(RecipM);

    // Stage 3: quotient correction, split into index and Q16 weight
    qe   = s2_prodz_q[2*VW-1:VW];
    rem5 = s2_v_q - ((qe << 2) + qe);
    z    = (rem5 >= VW'(5)) ? qe + VW'(1) : qe;
    if (s2_big_q) begin
      s3_idx_d = DMax;
      s3_q_d   = '0;
    end else begin
      s3_idx_d = z[16 +: DW];
      s3_q_d   = z[15:0];
    end

    // Stage 4: table lookups and slope
    t0        = TanhTab[{1'b0, s3_idx_q}];
    t1        = TanhTab[(DW + 1)'(s3_idx_q) + (DW + 1)'(1)];
    s4_diff_d = $signed({1'b0, t1}) - $signed({1'b0, t0});

    // Stage 5: slope times weight
    s5_prodi_d = s4_diff_q * $signed({1'b0, s4_q_q}) + RndIp;

    // Stage 6: interpolated point with sign, final shaper select
    soft_mag = $signed({2'b00, s5_t0_q}) + $signed(s5_prodi_q[IPW-1:16]);
    soft_w   = s5_neg_q ? -soft_mag : soft_mag;
    s6_w_d   = (shape_mode_q == ShapeSoft) ? AW'(soft_w) : s5_wbase_q;

    // Stage 7: dry and wet products
    m_cl     = (wet_mix_q > MixOne) ? MixOne : wet_mix_q;
    mix_w    = $signed({1'b0, m_cl});
    mix_d    = $signed({1'b0, MixOne - m_cl});
    s7_dry_d = s6_x_q * mix_d;
    s7_wet_d = mix_w * s6_w_q;

    // Stage 8: sum, round, saturate
    mix_sum = SumW'(s7_dry_q) + SumW'(s7_wet_q) + RndSum;
    y       = $signed(mix_sum[SumW-1:16]);
    if (y > YMax) begin
      s8_out_d = OutMax;
      s8_sat_d = 1'b1;
    end else if (y < YMin) begin
      s8_out_d = OutMin;
      s8_sat_d = 1'b1;
    end else begin
      s8_out_d = SW'(y);
      s8_sat_d = 1'b0;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_x_q    <= x_in;
      s0_prod_q <= s0_prod_d;
    end
    if (en[1]) begin
      s1_x_q   <= s0_x_q;
      s1_a_q   <= s1_a_d;
      s1_pos_q <= s1_pos_d;
      s1_big_q <= s1_big_d;
    end
    if (en[2]) begin
      s2_x_q     <= s1_x_q;
      s2_neg_q   <= s1_a_q[AW-1];
      s2_big_q   <= s1_big_q;
      s2_wbase_q <= s2_wbase_d;
      s2_v_q     <= s2_v_d;
      s2_prodz_q <= s2_prodz_d;
    end
    if (en[3]) begin
      s3_x_q     <= s2_x_q;
      s3_neg_q   <= s2_neg_q;
      s3_wbase_q <= s2_wbase_q;
      s3_idx_q   <= s3_idx_d;
      s3_q_q     <= s3_q_d;
    end
    if (en[4]) begin
      s4_x_q     <= s3_x_q;
      s4_neg_q   <= s3_neg_q;
      s4_wbase_q <= s3_wbase_q;
      s4_t0_q    <= t0;
      s4_diff_q  <= s4_diff_d;
      s4_q_q     <= s3_q_q;
    end
    if (en[5]) begin
      s5_x_q     <= s4_x_q;
      s5_neg_q   <= s4_neg_q;
      s5_wbase_q <= s4_wbase_q;
      s5_t0_q    <= s4_t0_q;
      s5_prodi_q <= s5_prodi_d;
    end
    if (en[6]) begin
      s6_x_q <= s5_x_q;
      s6_w_q <= s6_w_d;
    end
    if (en[7]) begin
      s7_dry_q <= s7_dry_d;
      s7_wet_q <= s7_wet_d;
    end
    if (en[8]) begin
      s8_out_q <= s8_out_d;
      s8_sat_q <= s8_sat_d;
    end
  end

  assign sample_out_o    = s8_out_q;
  assign out_saturated_o = s8_sat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  `WDM_ASSERT_IF(a_sat_at_rail, out_valid_o && out_saturated_o, (sample_out_o == OutMax) || (sample_out_o == OutMin), "saturation flag without a rail value")
  `WDM_ASSERT(a_full_on_backpressure, !in_ready_o |-> ((&vld_q) && !out_ready_i), "input stalled with room in the pipeline")
  `WDM_ASSERT_IF(a_idx_range, vld_q[3], s3_idx_q <= DMax, "tanh index past the last point")
  `WDM_ASSERT(a_beat_enters, (in_valid_i && in_ready_o) |=> vld_q[0], "accepted beat lost at entry")

endmodule
